// File: rtl/core/gha_pkg.sv
`timescale 1ns / 1ps

package gha_pkg;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GET     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESET   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd2;

    typedef struct packed {
        logic                valid_res;
        logic [STATUS_W-1:0] status;
    } t_res_ctl;

endpackage

// File: rtl/core/gha_ram.sv
`timescale 1ns / 1ps

module gha_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/gha_core.sv
`timescale 1ns / 1ps

module gha_core #(
    parameter int CAPACITY     = 1024,
    parameter int VERSION_BITS = 16,
    parameter int IW           = 10,
    parameter int LW           = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request side
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  logic [gha_pkg::MODE_W-1:0] i_mode,
    input  logic [IW-1:0]             i_idx,
    input  logic [VERSION_BITS-1:0]   i_ver,
    // result side
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output logic [IW-1:0]             o_res_index,
    output logic [VERSION_BITS-1:0]   o_res_version,
    output gha_pkg::t_res_ctl         o_res_ctl,
    output logic [LW-1:0]             o_res_live,
    // version memory
    output logic                      o_ver_we,
    output logic [IW-1:0]             o_ver_waddr,
    output logic [VERSION_BITS-1:0]   o_ver_wdata,
    output logic                      o_ver_re,
    output logic [IW-1:0]             o_ver_raddr,
    input  logic [VERSION_BITS-1:0]   i_ver_rdata,
    // free stack memory
    output logic                      o_stk_we,
    output logic [IW-1:0]             o_stk_waddr,
    output logic [IW-1:0]             o_stk_wdata,
    output logic                      o_stk_re,
    output logic [IW-1:0]             o_stk_raddr,
    input  logic [IW-1:0]             i_stk_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    logic [1:0]                  r_state, n_state;
    logic [LW-1:0]               r_depth, n_depth;
    logic [LW-1:0]               r_fresh, n_fresh;
    logic [gha_pkg::MODE_W-1:0]  r_mode;
    logic [IW-1:0]               r_idx;
    logic [VERSION_BITS-1:0]     r_ver;

    logic                        in_range;
    logic                        ver_ok;
    logic [LW-1:0]               depth_m1;

    assign in_range = (LW'(r_idx) < r_fresh);
    assign ver_ok   = (r_ver >= i_ver_rdata);
    assign depth_m1 = r_depth - LW'(1);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_live  = n_fresh - n_depth;

    always_comb begin
        n_state       = r_state;
        n_depth       = r_depth;
        n_fresh       = r_fresh;
        o_res_valid   = 1'b0;
        o_res_index   = '0;
        o_res_version = '0;
        o_res_ctl     = '{valid_res: 1'b0, status: gha_pkg::STATUS_OK};
        o_ver_we      = 1'b0;
        o_ver_waddr   = r_fresh[IW-1:0];
        o_ver_wdata   = '0;
        o_ver_re      = 1'b0;
        o_ver_raddr   = i_idx;
        o_stk_we      = 1'b0;
        o_stk_waddr   = r_depth[IW-1:0];
        o_stk_wdata   = r_idx;
        o_stk_re      = 1'b0;
        o_stk_raddr   = depth_m1[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    // Both reads go up front (stack only if not empty); mode decides use.
                    o_ver_re = 1'b1;
                    o_stk_re = (r_depth != '0);
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_mode == gha_pkg::MODE_CREATE && r_depth != '0) begin
                    // Pop: the slot came from the stack, its version needs one more read.
                    o_ver_re    = 1'b1;
                    o_ver_raddr = i_stk_rdata;
                    n_depth     = depth_m1;
                    n_state     = S_POP;
                end else if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                    unique case (r_mode)
                        gha_pkg::MODE_CREATE: begin
                            if (r_fresh < CAP_L) begin
                                o_ver_we    = 1'b1;
                                n_fresh     = r_fresh + LW'(1);
                                o_res_index = r_fresh[IW-1:0];
                                o_res_ctl   = '{valid_res: 1'b1, status: gha_pkg::STATUS_OK};
                            end else begin
                                o_res_ctl = '{valid_res: 1'b0, status: gha_pkg::STATUS_FULL};
                            end
                        end
                        gha_pkg::MODE_DESTROY: begin
                            if (in_range && ver_ok && r_depth < r_fresh) begin
                                o_ver_we    = 1'b1;
                                o_ver_waddr = r_idx;
                                o_ver_wdata = i_ver_rdata + VERSION_BITS'(1);
                                o_stk_we    = 1'b1;
                                n_depth     = r_depth + LW'(1);
                                o_res_ctl   = '{valid_res: 1'b1, status: gha_pkg::STATUS_OK};
                            end else begin
                                o_res_ctl = '{valid_res: 1'b0, status: gha_pkg::STATUS_STALE};
                            end
                        end
                        gha_pkg::MODE_CHECK: begin
                            if (in_range && ver_ok) begin
                                o_res_ctl = '{valid_res: 1'b1, status: gha_pkg::STATUS_OK};
                            end else begin
                                o_res_ctl = '{valid_res: 1'b0, status: gha_pkg::STATUS_STALE};
                            end
                        end
                        gha_pkg::MODE_GET: begin
                            if (in_range) begin
                                o_res_index   = r_idx;
                                o_res_version = i_ver_rdata;
                                o_res_ctl = '{valid_res: 1'b1, status: gha_pkg::STATUS_OK};
                            end else begin
                                o_res_ctl = '{valid_res: 1'b0, status: gha_pkg::STATUS_STALE};
                            end
                        end
                        gha_pkg::MODE_RESET: begin
                            n_depth = '0;
                            n_fresh = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                // The stack read data holds since no stack read is issued here.
                if (i_res_ready) begin
                    o_res_valid   = 1'b1;
                    o_res_index   = i_stk_rdata;
                    o_res_version = i_ver_rdata;
                    o_res_ctl     = '{valid_res: 1'b1, status: gha_pkg::STATUS_OK};
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_fresh <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_fresh <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_mode <= i_mode;
            r_idx  <= i_idx;
            r_ver  <= i_ver;
        end
    end

endmodule

// File: rtl/core/generational_handle_allocator_top.sv
`timescale 1ns / 1ps

// Generational handle allocator: hands out slot handles (index, version), recycles freed
// slots through a LIFO free stack and bumps a slot's version on destroy so that stale
// handles are caught. Requests are handled one at a time: when a request is accepted the
// version memory is read, and the free-stack memory too when the stack is not empty; the
// execute state then evaluates the result, writes it back and loads it into the output
// register. A create that pops a freed slot passes through a further pop state, because
// the slot's version can only be read once the stack read returns the index. The output
// register lets the next request be accepted while a result waits; a stalled output holds
// the block in its last state until the register frees. The reset mode clears the counters
// at once; the memories need no clearing pass.
module generational_handle_allocator_top #(
    parameter int CAPACITY     = 1024,
    parameter int VERSION_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // mode, slot_index, slot_version
    input  logic [((gha_pkg::MODE_W + $clog2(CAPACITY) + VERSION_BITS + 7) / 8) * 8 - 1:0]
                             i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // handle_index, handle_version, valid_res, status, live_count
    output logic [(($clog2(CAPACITY) + VERSION_BITS + 1 + gha_pkg::STATUS_W
                    + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0]
                             o_m_axis_tdata
);

    localparam int IW       = $clog2(CAPACITY);
    localparam int LW       = $clog2(CAPACITY + 1);
    localparam int OUT_BITS = IW + VERSION_BITS + 1 + gha_pkg::STATUS_W + LW;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int IDX_LO   = gha_pkg::MODE_W;
    localparam int VER_LO   = gha_pkg::MODE_W + IW;

    logic                      res_valid;
    logic                      res_ready;
    logic [IW-1:0]             res_index;
    logic [VERSION_BITS-1:0]   res_version;
    gha_pkg::t_res_ctl         res_ctl;
    logic [LW-1:0]             res_live;

    logic                      ver_we, ver_re;
    logic [IW-1:0]             ver_waddr, ver_raddr;
    logic [VERSION_BITS-1:0]   ver_wdata, ver_rdata;
    logic                      stk_we, stk_re;
    logic [IW-1:0]             stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_data;

    gha_core #(
        .CAPACITY     (CAPACITY),
        .VERSION_BITS (VERSION_BITS),
        .IW           (IW),
        .LW           (LW)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .o_req_ready   (o_s_axis_tready),
        .i_mode        (i_s_axis_tdata[gha_pkg::MODE_W-1:0]),
        .i_idx         (i_s_axis_tdata[IDX_LO +: IW]),
        .i_ver         (i_s_axis_tdata[VER_LO +: VERSION_BITS]),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res_index   (res_index),
        .o_res_version (res_version),
        .o_res_ctl     (res_ctl),
        .o_res_live    (res_live),
        .o_ver_we      (ver_we),
        .o_ver_waddr   (ver_waddr),
        .o_ver_wdata   (ver_wdata),
        .o_ver_re      (ver_re),
        .o_ver_raddr   (ver_raddr),
        .i_ver_rdata   (ver_rdata),
        .o_stk_we      (stk_we),
        .o_stk_waddr   (stk_waddr),
        .o_stk_wdata   (stk_wdata),
        .o_stk_re      (stk_re),
        .o_stk_raddr   (stk_raddr),
        .i_stk_rdata   (stk_rdata)
    );

    gha_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (VERSION_BITS)
    ) u_ver_ram (
        .i_clk   (i_clk),
        .i_we    (ver_we),
        .i_waddr (ver_waddr),
        .i_wdata (ver_wdata),
        .i_re    (ver_re),
        .i_raddr (ver_raddr),
        .o_rdata (ver_rdata)
    );

    gha_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (IW)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // The output register takes a new result when empty or when its transaction completes.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= OUT_W'({res_live, res_ctl.status, res_ctl.valid_res,
                                  res_version, res_index});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: tb/sv/handle_result_checker.sv
`timescale 1ns / 1ps

module handle_result_checker #(
    parameter int CAPACITY = 1024,
    parameter int IN_W     = 32,
    parameter int OUT_W    = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,
    output int               o_fail_count,
    output int               o_pending
);

    // Same layout as the result tdata, so a transaction can be cast straight in.
    typedef struct packed {
        logic [10:0] live;
        logic [1:0]  status;
        logic        valid_res;
        logic [15:0] version;
        logic [9:0]  index;
    } t_handle_result;

    logic [15:0]    slot_gen [CAPACITY];
    logic [9:0]     freed_slots [CAPACITY];
    int unsigned    freed_depth;
    int unsigned    fresh_next;
    t_handle_result expected_results [$];
    int             fail_count;
    int             printed;

    function automatic bit handle_current(logic [9:0] idx, logic [15:0] ver);
        if (idx >= fresh_next)
            return 1'b0;
        return ver >= slot_gen[idx];
    endfunction

    task automatic predict_handle_op(input logic [IN_W-1:0] d, output t_handle_result r);
        logic [2:0]  mode;
        logic [9:0]  idx;
        logic [15:0] ver;
        logic [9:0]  s;
        mode = d[2:0];
        idx  = d[12:3];
        ver  = d[28:13];
        r    = '0;
        unique case (mode)
            gha_pkg::MODE_CREATE: begin
                if (freed_depth > 0) begin
                    freed_depth--;
                    s = freed_slots[freed_depth];
                    r.index     = s;
                    r.version   = slot_gen[s];
                    r.valid_res = 1'b1;
                end else if (fresh_next < CAPACITY) begin
                    s = fresh_next[9:0];
                    fresh_next++;
                    slot_gen[s] = '0;
                    r.index     = s;
                    r.valid_res = 1'b1;
                end else begin
                    r.status = gha_pkg::STATUS_FULL;
                end
            end
            gha_pkg::MODE_DESTROY: begin
                // A forged newer version on a freed slot still passes, as long as
                // the free stack cannot grow past the number of used slots.
                if (handle_current(idx, ver) && freed_depth < fresh_next) begin
                    slot_gen[idx] = slot_gen[idx] + 16'd1;
                    freed_slots[freed_depth] = idx;
                    freed_depth++;
                    r.valid_res = 1'b1;
                end else begin
                    r.status = gha_pkg::STATUS_STALE;
                end
            end
            gha_pkg::MODE_CHECK: begin
                if (handle_current(idx, ver))
                    r.valid_res = 1'b1;
                else
                    r.status = gha_pkg::STATUS_STALE;
            end
            gha_pkg::MODE_GET: begin
                if (idx < fresh_next) begin
                    r.index     = idx;
                    r.version   = slot_gen[idx];
                    r.valid_res = 1'b1;
                end else begin
                    r.status = gha_pkg::STATUS_STALE;
                end
            end
            gha_pkg::MODE_RESET: begin
                freed_depth = 0;
                fresh_next  = 0;
            end
            default: ;
        endcase
        r.live = 11'(fresh_next - freed_depth);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (printed < 50) begin
            printed++;
            $display("[%0t] result mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        end
    endtask

    initial begin
        fail_count  = 0;
        printed     = 0;
        freed_depth = 0;
        fresh_next  = 0;
    end

    always @(posedge i_clk) begin
        t_handle_result got;
        t_handle_result want;
        if (!i_rst_n) begin
            freed_depth = 0;
            fresh_next  = 0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_handle_result'(i_m_tdata[39:0]);
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request waiting", int'(got), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.index !== want.index)
                        report_mismatch("handle_index", int'(got.index), int'(want.index));
                    if (got.version !== want.version)
                        report_mismatch("handle_version", int'(got.version),
                                        int'(want.version));
                    if (got.valid_res !== want.valid_res)
                        report_mismatch("valid_res", int'(got.valid_res),
                                        int'(want.valid_res));
                    if (got.status !== want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.live !== want.live)
                        report_mismatch("live_count", int'(got.live), int'(want.live));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_handle_op(i_s_tdata, want);
                expected_results = {expected_results, want};
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: tb/sv/generational_handle_allocator_top_tb.sv
`timescale 1ns / 1ps

module generational_handle_allocator_top_tb;

    localparam int CAPACITY     = 1024;
    localparam int VERSION_BITS = 16;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int IN_W         = ((gha_pkg::MODE_W + IDX_W + VERSION_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((IDX_W + VERSION_BITS + 1 + gha_pkg::STATUS_W
                                    + $clog2(CAPACITY + 1) + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 200000;

    // Modes 5 to 7 are unused and must behave as no operation.
    localparam logic [gha_pkg::MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // mode, slot_index, slot_version
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // handle_index, handle_version, valid_res, status, live_count

    int fail_count;
    int pending;
    bit quiet;
    int fresh_hint;
    int mode_count [8];
    int cycles;

    generational_handle_allocator_top #(
        .CAPACITY    (CAPACITY),
        .VERSION_BITS(VERSION_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    handle_result_checker #(
        .CAPACITY(CAPACITY),
        .IN_W    (IN_W),
        .OUT_W   (OUT_W)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles with %0d results outstanding",
                         cycles, pending);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side backpressure.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_tready = quiet || ($urandom_range(0, 99) >= 11);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_request(input logic [gha_pkg::MODE_W-1:0] mode, input logic [9:0] idx,
                                input logic [15:0] ver);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 11) begin
                s_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = '0;
        s_tdata[28:0] = {ver, idx, mode};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        mode_count[mode]++;
        if (mode == gha_pkg::MODE_CREATE && fresh_hint < CAPACITY)
            fresh_hint++;
        else if (mode == gha_pkg::MODE_RESET)
            fresh_hint = 0;
    endtask

    task automatic random_request(input bit allow_reset);
        int          r;
        logic [2:0]  mode;
        logic [9:0]  idx;
        logic [15:0] ver;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85)
            idx = 10'($urandom_range(0, fresh_hint));
        else
            idx = 10'($urandom);
        if ($urandom_range(0, 99) < 75)
            ver = 16'($urandom_range(0, 3));
        else
            ver = 16'($urandom);
        if (r < 30)
            mode = gha_pkg::MODE_CREATE;
        else if (r < 55)
            mode = gha_pkg::MODE_DESTROY;
        else if (r < 75)
            mode = gha_pkg::MODE_CHECK;
        else if (r < 90)
            mode = gha_pkg::MODE_GET;
        else if (r < 92)
            mode = allow_reset ? gha_pkg::MODE_RESET : gha_pkg::MODE_CHECK;
        else if (r < 95)
            mode = MODE_SPARE_FIRST + 3'($urandom_range(0, 2));
        else begin
            // Noise: every field fully random.
            mode = 3'($urandom);
            idx  = 10'($urandom);
            ver  = 16'($urandom);
            if (!allow_reset && mode == gha_pkg::MODE_RESET)
                mode = gha_pkg::MODE_GET;
        end
        send_request(mode, idx, ver);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        quiet      = 1'b0;
        fresh_hint = 0;
        foreach (mode_count[k])
            mode_count[k] = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Out-of-range requests on an empty allocator, then three creates and a check.
        send_request(gha_pkg::MODE_GET,     10'd0,    16'd0);
        send_request(gha_pkg::MODE_CHECK,   10'd1023, 16'hFFFF);
        send_request(gha_pkg::MODE_DESTROY, 10'd0,    16'd0);
        send_request(gha_pkg::MODE_CREATE,  10'd0,    16'd0);
        send_request(gha_pkg::MODE_CREATE,  10'd0,    16'd0);
        send_request(gha_pkg::MODE_CREATE,  10'd0,    16'd0);
        send_request(gha_pkg::MODE_CHECK,   10'd0,    16'd0);
        // Destroy, then the stale handle is rejected by check and destroy.
        send_request(gha_pkg::MODE_DESTROY, 10'd1,    16'd0);
        send_request(gha_pkg::MODE_CHECK,   10'd1,    16'd0);
        send_request(gha_pkg::MODE_DESTROY, 10'd1,    16'd0);
        send_request(gha_pkg::MODE_GET,     10'd1,    16'd0);
        // A forged newer version on a freed slot is taken while the stack has room.
        send_request(gha_pkg::MODE_DESTROY, 10'd1,    16'hFFFF);
        send_request(gha_pkg::MODE_DESTROY, 10'd2,    16'd0);
        // Stack depth equals the used slots, so this valid handle is refused.
        send_request(gha_pkg::MODE_DESTROY, 10'd0,    16'hFFFF);
        send_request(gha_pkg::MODE_CREATE,  10'd0,    16'd0);
        send_request(gha_pkg::MODE_CREATE,  10'd0,    16'd0);
        send_request(gha_pkg::MODE_CREATE,  10'd0,    16'd0);
        send_request(gha_pkg::MODE_CREATE,  10'd0,    16'd0);
        send_request(MODE_SPARE_FIRST,        10'd1023, 16'hFFFF);
        send_request(MODE_SPARE_FIRST + 3'd1, 10'd0,    16'd0);
        send_request(MODE_SPARE_FIRST + 3'd2, 10'd512,  16'h8000);
        send_request(gha_pkg::MODE_CHECK,   10'd3,    16'hFFFF);
        send_request(gha_pkg::MODE_RESET,   10'd0,    16'd0);
        send_request(gha_pkg::MODE_GET,     10'd0,    16'd0);
        send_request(gha_pkg::MODE_CREATE,  10'd0,    16'd0);

        repeat (200) random_request(1'b1);

        // Fill every slot without any idling, then run past the full point.
        quiet = 1'b1;
        send_request(gha_pkg::MODE_RESET, 10'd0, 16'd0);
        repeat (CAPACITY + 6)
            send_request(gha_pkg::MODE_CREATE, 10'($urandom), 16'($urandom));
        send_request(gha_pkg::MODE_CHECK, 10'd1023, 16'd0);
        send_request(gha_pkg::MODE_GET,   10'd1023, 16'd0);
        quiet = 1'b0;
        repeat (150) random_request(1'b0);

        repeat (100) random_request(1'b1);

        s_tvalid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("covered %0d creates, %0d destroys, %0d checks, %0d gets, %0d resets,",
                 mode_count[gha_pkg::MODE_CREATE], mode_count[gha_pkg::MODE_DESTROY],
                 mode_count[gha_pkg::MODE_CHECK], mode_count[gha_pkg::MODE_GET],
                 mode_count[gha_pkg::MODE_RESET]);
        $display("%0d unused-mode requests and a fill of all %0d slots past full",
                 mode_count[MODE_SPARE_FIRST] + mode_count[MODE_SPARE_FIRST + 3'd1]
                 + mode_count[MODE_SPARE_FIRST + 3'd2], CAPACITY);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
